// File: rtl/ecal_pkg.sv
`default_nettype none
package ecal_pkg;

   localparam int unsigned PC_W   = 4;
   localparam int unsigned DAYS_W = 16;
   localparam int unsigned YEAR_W = 12;

   localparam logic [YEAR_W-1:0] EPOCH_YEAR   = 12'd1970;
   // 1970-01-01 was a Thursday
   localparam logic [2:0]        EPOCH_WEEKDAY = 3'd4;

   // Divisor choices for the shared divider
   typedef enum logic [1:0] {
      DIV_BY_60 = 2'd0,
      DIV_BY_24 = 2'd1,
      DIV_BY_7  = 2'd2
   } div_sel_type;

   // Datapath operations, one per control word
   typedef enum logic [3:0] {
      OP_IDLE      = 4'd0,
      OP_DIV       = 4'd1,
      OP_SAVE_SEC  = 4'd2,
      OP_SAVE_MIN  = 4'd3,
      OP_SAVE_HOUR = 4'd4,
      OP_SAVE_WDAY = 4'd5,
      OP_YEAR      = 4'd6,
      OP_MONTH     = 4'd7,
      OP_EMIT      = 4'd8,
      OP_NOP       = 4'd9
   } op_type;

   // Jump conditions: jump to target when true, else fall through
   typedef enum logic [2:0] {
      C_NEVER    = 3'd0,
      C_ALWAYS   = 3'd1,
      C_NO_REQ   = 3'd2,
      C_DIV_BUSY = 3'd3,
      C_YEAR_GE  = 3'd4,
      C_MONTH_GE = 3'd5,
      C_OUT_FULL = 3'd6
   } cond_type;

   typedef struct packed {
      op_type           op;
      div_sel_type      sel;
      cond_type         cond;
      logic [PC_W-1:0]  target;
   } uword_type;

   typedef struct packed {
      logic        load;
      logic        step;
      div_sel_type sel;
   } div_ctl_type;

   // Microprogram
   function automatic uword_type ucode_rom(input logic [PC_W-1:0] pc);
      uword_type w;
      w = '{op: OP_NOP, sel: DIV_BY_60, cond: C_ALWAYS, target: 4'd0};
      unique case (pc)
         4'd0:  w = '{op: OP_IDLE,      sel: DIV_BY_60, cond: C_NO_REQ,   target: 4'd0};
         4'd1:  w = '{op: OP_DIV,       sel: DIV_BY_60, cond: C_DIV_BUSY, target: 4'd1};
         4'd2:  w = '{op: OP_SAVE_SEC,  sel: DIV_BY_60, cond: C_NEVER,    target: 4'd0};
         4'd3:  w = '{op: OP_DIV,       sel: DIV_BY_60, cond: C_DIV_BUSY, target: 4'd3};
         4'd4:  w = '{op: OP_SAVE_MIN,  sel: DIV_BY_60, cond: C_NEVER,    target: 4'd0};
         4'd5:  w = '{op: OP_DIV,       sel: DIV_BY_24, cond: C_DIV_BUSY, target: 4'd5};
         4'd6:  w = '{op: OP_SAVE_HOUR, sel: DIV_BY_24, cond: C_NEVER,    target: 4'd0};
         4'd7:  w = '{op: OP_DIV,       sel: DIV_BY_7,  cond: C_DIV_BUSY, target: 4'd7};
         4'd8:  w = '{op: OP_SAVE_WDAY, sel: DIV_BY_7,  cond: C_NEVER,    target: 4'd0};
         4'd9:  w = '{op: OP_YEAR,      sel: DIV_BY_60, cond: C_YEAR_GE,  target: 4'd9};
         4'd10: w = '{op: OP_MONTH,     sel: DIV_BY_60, cond: C_MONTH_GE, target: 4'd10};
         4'd11: w = '{op: OP_EMIT,      sel: DIV_BY_60, cond: C_OUT_FULL, target: 4'd11};
         default: w = '{op: OP_NOP,     sel: DIV_BY_60, cond: C_ALWAYS,   target: 4'd0};
      endcase
      return w;
   endfunction

   function automatic logic [5:0] divisor_of(input div_sel_type sel);
      logic [5:0] d;
      unique case (sel)
         DIV_BY_60: d = 6'd60;
         DIV_BY_24: d = 6'd24;
         DIV_BY_7:  d = 6'd7;
         default:   d = 6'd60;
      endcase
      return d;
   endfunction

   // Scaled reciprocals: quotient is (x * recip) >> 37, 36 or 34, exact for the
   // dividends each divisor sees (any 32-bit value for 60 and 24, below 2^31 for 7)
   function automatic logic [31:0] recip_of(input div_sel_type sel);
      logic [31:0] m;
      unique case (sel)
         DIV_BY_60: m = 32'h8888_8889;
         DIV_BY_24: m = 32'hAAAA_AAAB;
         DIV_BY_7:  m = 32'h9249_2493;
         default:   m = 32'h8888_8889;
      endcase
      return m;
   endfunction

   // Years 1970..2106 hold one century only: 2000 is leap, 2100 is not
   function automatic logic is_leap(input logic [YEAR_W-1:0] year);
      return (year[1:0] == 2'b00) && (year != 12'd2100);
   endfunction

   function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
      logic [4:0] d;
      case (month) inside
         4'd2:                      d = leap ? 5'd29 : 5'd28;
         4'd4, 4'd6, 4'd9, 4'd11:   d = 5'd30;
         default:                   d = 5'd31;
      endcase
      return d;
   endfunction

endpackage
`default_nettype wire

// File: rtl/ecal_div.sv
`default_nettype none
// Constant-divisor divide by reciprocal multiplication in three steps:
// scale the dividend, shift out the quotient, back-multiply for the remainder
module ecal_div (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire ecal_pkg::div_ctl_type ctl,
   input  wire logic [31:0]          load_value,
   output logic [31:0]               quot,
   output logic [5:0]                remainder,
   output logic                      busy
);

   logic [31:0] x_ff, x_in;
   logic [63:0] prod_ff, prod_in;
   logic [31:0] q_ff, q_in;
   logic [5:0]  rem_ff, rem_in;
   logic [1:0]  cnt_ff, cnt_in;

   // Advance one stage per step: product, quotient, remainder
   always_comb begin
      logic [5:0]  d;
      logic [31:0] q_calc;
      logic [31:0] diff;
      d = ecal_pkg::divisor_of(ctl.sel);
      unique case (ctl.sel)
         ecal_pkg::DIV_BY_60: q_calc = {5'd0, prod_ff[63:37]};
         ecal_pkg::DIV_BY_24: q_calc = {4'd0, prod_ff[63:36]};
         ecal_pkg::DIV_BY_7:  q_calc = {2'd0, prod_ff[63:34]};
         default:             q_calc = {5'd0, prod_ff[63:37]};
      endcase
      diff    = x_ff - (q_ff * {26'd0, d});
      x_in    = x_ff;
      prod_in = prod_ff;
      q_in    = q_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      if (ctl.load) begin
         x_in   = load_value;
         cnt_in = 2'd0;
      end else if (ctl.step) begin
         case (cnt_ff)
            2'd0:    prod_in = {32'd0, x_ff} * {32'd0, ecal_pkg::recip_of(ctl.sel)};
            2'd1:    q_in    = q_calc;
            default: rem_in  = diff[5:0];
         endcase
         cnt_in = (cnt_ff == 2'd2) ? 2'd0 : cnt_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
      x_ff    <= x_in;
      prod_ff <= prod_in;
      q_ff    <= q_in;
      rem_ff  <= rem_in;
   end

   assign quot      = q_ff;
   assign remainder = rem_ff;
   assign busy      = (cnt_ff != 2'd2);

endmodule
`default_nettype wire

// File: rtl/epoch_seconds_to_calendar.sv
// Timing from request accept to rsp_valid grows with Y, the number of whole years
// after 1970 (0..136), and M, the whole months peeled (0..11).
// One request at a time: the next is accepted only once the result is loaded and the
// sequencer is back at idle; most of the time goes in the one-year-per-cycle loop.
// Reset: synchronous, active high; returns the sequencer to idle and drops rsp_valid.
`default_nettype none
module epoch_seconds_to_calendar (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [31:0] req_epoch_seconds,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [11:0]      rsp_year_full,
   output logic [3:0]       rsp_month_number,
   output logic [4:0]       rsp_day_of_month,
   output logic [4:0]       rsp_hour_of_day,
   output logic [5:0]       rsp_minute_of_hour,
   output logic [5:0]       rsp_second_of_minute,
   output logic [2:0]       rsp_weekday
);

   logic [ecal_pkg::PC_W-1:0]   pc_ff, pc_in;
   ecal_pkg::uword_type         uw;
   ecal_pkg::div_ctl_type       div_ctl;
   logic [31:0]                 div_load;
   logic [31:0]                 quot;
   logic [5:0]                  remainder;
   logic                        div_busy;

   logic [5:0]                  sec_ff, sec_in;
   logic [5:0]                  min_ff, min_in;
   logic [4:0]                  hour_ff, hour_in;
   logic [2:0]                  wday_ff, wday_in;
   logic [ecal_pkg::DAYS_W-1:0] days_ff, days_in;
   logic [ecal_pkg::YEAR_W-1:0] year_ff, year_in;
   logic [3:0]                  month_ff, month_in;

   logic                        leap;
   logic [8:0]                  ylen;
   logic [4:0]                  mlen;
   logic                        year_ge;
   logic                        month_ge;
   logic                        out_full;
   logic                        emit;
   logic                        jump;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [16:0]                 days_off;

   // Fetch the control word for the current step
   assign uw        = ecal_pkg::ucode_rom(pc_ff);
   assign req_stall = (uw.op != ecal_pkg::OP_IDLE);

   // Loop conditions
   assign leap     = ecal_pkg::is_leap(year_ff);
   assign ylen     = leap ? 9'd366 : 9'd365;
   assign mlen     = ecal_pkg::month_len(month_ff, leap);
   assign year_ge  = (days_ff >= {7'd0, ylen});
   assign month_ge = (month_ff != 4'd12) && (days_ff >= {11'd0, mlen});
   assign out_full = rsp_valid_ff && rsp_stall;
   assign emit     = (uw.op == ecal_pkg::OP_EMIT) && !out_full;
   assign days_off = {1'b0, quot[15:0]} + {14'd0, ecal_pkg::EPOCH_WEEKDAY};

   // Divider control
   always_comb begin
      div_ctl.sel  = uw.sel;
      div_ctl.step = (uw.op == ecal_pkg::OP_DIV);
      div_ctl.load = 1'b0;
      div_load     = quot;
      unique case (uw.op) inside
         ecal_pkg::OP_IDLE: begin
            div_ctl.load = req_valid;
            div_load     = req_epoch_seconds;
         end
         ecal_pkg::OP_SAVE_SEC, ecal_pkg::OP_SAVE_MIN: begin
            div_ctl.load = 1'b1;
         end
         ecal_pkg::OP_SAVE_HOUR: begin
            // weekday is (days since epoch + Thursday) mod 7
            div_ctl.load = 1'b1;
            div_load     = {15'd0, days_off};
         end
         default: begin
            div_ctl.load = 1'b0;
         end
      endcase
   end

   ecal_div u_div (
      .clock      (clock),
      .reset      (reset),
      .ctl        (div_ctl),
      .load_value (div_load),
      .quot       (quot),
      .remainder  (remainder),
      .busy       (div_busy)
   );

   // Evaluate the jump condition and advance the step counter
   always_comb begin
      unique case (uw.cond)
         ecal_pkg::C_NEVER:    jump = 1'b0;
         ecal_pkg::C_ALWAYS:   jump = 1'b1;
         ecal_pkg::C_NO_REQ:   jump = !req_valid;
         ecal_pkg::C_DIV_BUSY: jump = div_busy;
         ecal_pkg::C_YEAR_GE:  jump = year_ge;
         ecal_pkg::C_MONTH_GE: jump = month_ge;
         ecal_pkg::C_OUT_FULL: jump = out_full;
         default:              jump = 1'b0;
      endcase
      pc_in = jump ? uw.target : pc_ff + 4'd1;
   end

   // Datapath register updates
   always_comb begin
      sec_in   = sec_ff;
      min_in   = min_ff;
      hour_in  = hour_ff;
      wday_in  = wday_ff;
      days_in  = days_ff;
      year_in  = year_ff;
      month_in = month_ff;
      unique case (uw.op)
         ecal_pkg::OP_SAVE_SEC: sec_in = remainder;
         ecal_pkg::OP_SAVE_MIN: min_in = remainder;
         ecal_pkg::OP_SAVE_HOUR: begin
            hour_in  = remainder[4:0];
            days_in  = quot[ecal_pkg::DAYS_W-1:0];
            year_in  = ecal_pkg::EPOCH_YEAR;
            month_in = 4'd1;
         end
         ecal_pkg::OP_SAVE_WDAY: wday_in = remainder[2:0];
         ecal_pkg::OP_YEAR: begin
            if (year_ge) begin
               days_in = days_ff - {7'd0, ylen};
               year_in = year_ff + 12'd1;
            end
         end
         ecal_pkg::OP_MONTH: begin
            if (month_ge) begin
               days_in  = days_ff - {11'd0, mlen};
               month_in = month_ff + 4'd1;
            end
         end
         default: begin
            sec_in = sec_ff;
         end
      endcase
   end

   // Hold the result until taken; load a new one when the slot frees
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (emit) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pc_ff        <= pc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      sec_ff   <= sec_in;
      min_ff   <= min_in;
      hour_ff  <= hour_in;
      wday_ff  <= wday_in;
      days_ff  <= days_in;
      year_ff  <= year_in;
      month_ff <= month_in;
      if (emit) begin
         rsp_year_full        <= year_ff;
         rsp_month_number     <= month_ff;
         rsp_day_of_month     <= days_ff[4:0] + 5'd1;
         rsp_hour_of_day      <= hour_ff;
         rsp_minute_of_hour   <= min_ff;
         rsp_second_of_minute <= sec_ff;
         rsp_weekday          <= wday_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   // A request always starts the program at the first divide step
   a_accept_starts : assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (pc_ff == 4'd1))
      else $error("request accepted but sequencer did not start");

   // Emitting into a free slot makes a result visible
   a_emit_valid : assert property (@(posedge clock) disable iff (reset)
      emit |=> rsp_valid_ff)
      else $error("emit did not raise rsp_valid");

   // Month walk starts with less than one year of days left
   a_month_days : assert property (@(posedge clock) disable iff (reset)
      (uw.op == ecal_pkg::OP_MONTH) |-> (days_ff < 16'd366))
      else $error("month walk entered with a year or more of days");

   // Day of month never runs past the month in the emit step
   a_emit_day : assert property (@(posedge clock) disable iff (reset)
      (uw.op == ecal_pkg::OP_EMIT) |-> (days_ff < {11'd0, mlen}))
      else $error("day count exceeds month length at emit");

   // Idle step only follows the final jump or a wait
   a_idle_entry : assert property (@(posedge clock) disable iff (reset)
      ((pc_ff == 4'd0) && !$past(reset) && ($past(pc_ff) != 4'd0))
         |-> ($past(pc_ff) == 4'd12))
      else $error("sequencer reached idle from an unexpected step");

endmodule
`default_nettype wire
